### rtl/salc_pkg.sv
// Package for the set-associative LRU cache: geometry constants, types, state enum.
// No dependencies.
`timescale 1ns / 1ps
package salc_pkg;
  localparam int SET_COUNT  = 64;
  localparam int WAY_COUNT  = 4;
  localparam int BLOCK_BYTES = 16;
  localparam int ADDR_BITS  = 16;
  localparam int MAX_ACCESS_BYTES = 8;

  localparam int OFF_BITS  = $clog2(BLOCK_BYTES);
  localparam int SET_BITS  = $clog2(SET_COUNT);
  localparam int WAY_BITS  = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int TAG_BITS  = ADDR_BITS - OFF_BITS - SET_BITS;
  localparam int LINE_BITS = 8 * BLOCK_BYTES;
  localparam int BLK_BITS  = ADDR_BITS - OFF_BITS;
  localparam int MEM_WORDS = 1 << BLK_BITS;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  typedef struct packed {
    logic                   op;
    logic [ADDR_BITS-1:0]   address;
    logic [3:0]             access_size;
    logic [63:0]            store_data;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] load_data;
  } rsp_t;

  // Per-way metadata word
  typedef struct packed {
    logic                valid;
    logic [WAY_BITS-1:0] rank;
    logic [TAG_BITS-1:0] tag;
  } meta_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_FILL, ST_UPDATE, ST_RESP
  } state_t;
endpackage

### rtl/salc_if.sv
// Valid/ready channel interfaces carrying a request (req_t) or response (rsp_t) payload.
// Depends on salc_pkg.
`timescale 1ns / 1ps
interface salc_req_if;
  import salc_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface salc_rsp_if;
  import salc_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/set_assoc_lru_cache_unit.sv
// Top level of the set-associative LRU cache; ties the controller to main memory.
// Depends on salc_pkg, salc_if, salc_mem, salc_ctrl.
`timescale 1ns / 1ps
// After reset the block clears its 4096-block main memory, one block a cycle,
// before it accepts a first access. An access then steps from idle through
// lookup, update and response on a hit or write-through store miss, and
// adds a fill state on other misses, which holds the registered read of the
// block-wide main memory, while a victim write-back overlaps the lookup. The
// response state holds until ready is seen. One access is in flight at a time.
module set_assoc_lru_cache_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_wdata,
  salc_req_if.sink         req,
  salc_rsp_if.source       rsp
);
  import salc_pkg::*;
  logic wt;
  logic                 mem_we;
  logic [BLK_BITS-1:0]  mem_waddr, mem_raddr;
  logic [LINE_BITS-1:0] mem_wdata, mem_rdata;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) wt <= 1'b0;
    else if (cfg_we) wt <= cfg_wdata[0];
  end

  salc_ctrl u_ctrl (
    .clk, .rst, .wt,
    .req_valid(req.valid), .req(req.payload), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(rsp.payload),
    .mem_we, .mem_waddr, .mem_wdata, .mem_raddr, .mem_rdata
  );

  salc_mem u_mem (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );
endmodule

### rtl/salc_mem.sv
// Main memory: one block per word, sync read, one write port. Cleared by the
// controller sweep after reset. Depends on salc_pkg.
`timescale 1ns / 1ps
module salc_mem (
  input  logic                            clk,
  input  logic                            we,
  input  logic [salc_pkg::BLK_BITS-1:0]   waddr,
  input  logic [salc_pkg::LINE_BITS-1:0]  wdata,
  input  logic [salc_pkg::BLK_BITS-1:0]   raddr,
  output logic [salc_pkg::LINE_BITS-1:0]  rdata
);
  import salc_pkg::*;
  logic [LINE_BITS-1:0] mem [MEM_WORDS];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/salc_ctrl.sv
// Cache controller: metadata and line memories, lookup, replacement, fill and
// write-back sequencing. Depends on salc_pkg; drives the salc_mem ports via the top.
`timescale 1ns / 1ps
module salc_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wt,
  input  logic                           req_valid,
  input  salc_pkg::req_t                 req,
  output logic                           req_ready,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output salc_pkg::rsp_t                 rsp,
  output logic                           mem_we,
  output logic [salc_pkg::BLK_BITS-1:0]  mem_waddr,
  output logic [salc_pkg::LINE_BITS-1:0] mem_wdata,
  output logic [salc_pkg::BLK_BITS-1:0]  mem_raddr,
  input  logic [salc_pkg::LINE_BITS-1:0] mem_rdata
);
  import salc_pkg::*;

  // metadata and data stores: one row per set, all ways side by side
  meta_t                meta_mem [SET_COUNT][WAY_COUNT];
  logic [LINE_BITS-1:0] data_mem [SET_COUNT][WAY_COUNT];
  meta_t                meta_rd  [WAY_COUNT];
  logic [LINE_BITS-1:0] data_rd  [WAY_COUNT];

  state_t state, state_next;
  req_t   cur;
  logic [BLK_BITS:0] clr_cnt;
  logic              hit_q;
  logic [WAY_BITS-1:0] way_q;
  logic              alloc_q;
  logic [63:0]       ldata_q;

  logic [OFF_BITS-1:0] off;
  logic [SET_BITS-1:0] set_idx;
  logic [TAG_BITS-1:0] tag;
  assign off     = cur.address[OFF_BITS-1:0];
  assign set_idx = cur.address[OFF_BITS +: SET_BITS];
  assign tag     = cur.address[ADDR_BITS-1 -: TAG_BITS];

  // lookup and victim choice on the registered row
  logic                hit_c, any_inv;
  logic [WAY_BITS-1:0] hit_way, inv_way, lru_way, sel_way;
  always_comb begin
    hit_c = 1'b0; hit_way = '0; any_inv = 1'b0; inv_way = '0; lru_way = '0;
    for (int k = 0; k < WAY_COUNT; k++) begin
      if (meta_rd[k].valid && meta_rd[k].tag == tag) begin
        hit_c = 1'b1; hit_way = WAY_BITS'(k);
      end
      if (meta_rd[k].rank == WAY_BITS'(WAY_COUNT-1)) lru_way = WAY_BITS'(k);
    end
    for (int k = WAY_COUNT-1; k >= 0; k--)
      if (!meta_rd[k].valid) begin any_inv = 1'b1; inv_way = WAY_BITS'(k); end
    sel_way = hit_c ? hit_way : (any_inv ? inv_way : lru_way);
  end

  // effective byte mask of the access within the block
  logic [3:0] nbytes;
  logic [OFF_BITS:0] room;
  logic [BLOCK_BYTES-1:0] bmask;
  always_comb begin
    nbytes = (cur.access_size > 4'(MAX_ACCESS_BYTES)) ? 4'(MAX_ACCESS_BYTES)
                                                        : cur.access_size;
    room = (OFF_BITS+1)'(BLOCK_BYTES) - {1'b0, off};
    if ({{(OFF_BITS+1 > 4 ? OFF_BITS-3 : 0){1'b0}}, nbytes} > 
        (OFF_BITS+1 > 4 ? OFF_BITS+1 : 4)'(room))
      nbytes = 4'(room);
    for (int b = 0; b < BLOCK_BYTES; b++)
      bmask[b] = (b >= int'(off)) && (b < int'(off) + int'(nbytes));
  end

  // line merged with store bytes
  logic [LINE_BITS-1:0] base_line, merged;
  logic [63:0] ldata_c;
  always_comb begin
    base_line = (state == ST_UPDATE && !hit_q) ? mem_rdata : data_rd[way_q];
    merged = base_line;
    ldata_c = '0;
    for (int b = 0; b < BLOCK_BYTES; b++)
      if (bmask[b]) merged[8*b +: 8] = cur.store_data[8*(b-int'(off)) +: 8];
    for (int k = 0; k < MAX_ACCESS_BYTES; k++)
      if (k < int'(nbytes))
        ldata_c[8*k +: 8] = base_line[8*(int'(off)+k) +: 8];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_cnt == (BLK_BITS+1)'(MEM_WORDS-1)) state_next = ST_IDLE;
      ST_IDLE:   if (req_valid) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = hit_c ? ST_UPDATE :
                   ((cur.op == OP_STORE && wt) ? ST_UPDATE : ST_FILL);
      ST_FILL:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_RESP;
      ST_RESP:   if (rsp_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready = (state == ST_IDLE);
    rsp_valid = (state == ST_RESP);
    rsp.hit = hit_q;
    rsp.load_data = ldata_q;
    mem_raddr = cur.address[ADDR_BITS-1:OFF_BITS];
    mem_we = 1'b0;
    mem_waddr = {meta_rd[sel_way].tag, set_idx};
    mem_wdata = data_rd[sel_way];
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_cnt[BLK_BITS-1:0];
        mem_wdata = '0;
      end
      ST_LOOKUP: mem_we = !hit_c && !wt && cur.op == OP_LOAD ? !any_inv :
                          (!hit_c && !wt && !any_inv);
      // write-through store: only the accessed bytes change in memory
      ST_UPDATE: if (wt && cur.op == OP_STORE) begin
        mem_we = 1'b1;
        mem_waddr = cur.address[ADDR_BITS-1:OFF_BITS];
        mem_wdata = mem_rdata;
        for (int b = 0; b < BLOCK_BYTES; b++)
          if (bmask[b]) mem_wdata[8*b +: 8] = cur.store_data[8*(b-int'(off)) +: 8];
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // request capture, lookup results, response data
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) cur <= req;
    if (state == ST_LOOKUP) begin
      hit_q   <= hit_c;
      way_q   <= sel_way;
      alloc_q <= !hit_c && !(cur.op == OP_STORE && wt);
    end
    if (state == ST_UPDATE) ldata_q <= (cur.op == OP_LOAD) ? ldata_c : '0;
  end

  // metadata memory: cleared (ranks = way number) during sweep, RMW on update
  logic meta_we;
  meta_t meta_wr [WAY_COUNT];
  logic [SET_BITS-1:0] meta_wa;
  always_comb begin
    meta_we = 1'b0;
    meta_wa = set_idx;
    for (int k = 0; k < WAY_COUNT; k++) meta_wr[k] = meta_rd[k];
    if (state == ST_CLEAR) begin
      meta_we = clr_cnt < (BLK_BITS+1)'(SET_COUNT);
      meta_wa = clr_cnt[SET_BITS-1:0];
      for (int k = 0; k < WAY_COUNT; k++) begin
        meta_wr[k].valid = 1'b0;
        meta_wr[k].rank = WAY_BITS'(k);
        meta_wr[k].tag = '0;
      end
    end else if (state == ST_UPDATE && (hit_q || alloc_q)) begin
      meta_we = 1'b1;
      for (int k = 0; k < WAY_COUNT; k++)
        if (meta_rd[k].rank < meta_rd[way_q].rank)
          meta_wr[k].rank = meta_rd[k].rank + 1'b1;
      meta_wr[way_q].rank = '0;
      meta_wr[way_q].valid = 1'b1;
      meta_wr[way_q].tag = tag;
    end
  end

  logic [SET_BITS-1:0] rd_set;
  assign rd_set = (state == ST_IDLE) ? req.address[OFF_BITS +: SET_BITS] : set_idx;

  always_ff @(posedge clk) begin
    if (meta_we) for (int k = 0; k < WAY_COUNT; k++) meta_mem[meta_wa][k] <= meta_wr[k];
    for (int k = 0; k < WAY_COUNT; k++) meta_rd[k] <= meta_mem[rd_set][k];
  end

  // line data memory
  logic data_we;
  assign data_we = (state == ST_UPDATE) && (hit_q || alloc_q);
  always_ff @(posedge clk) begin
    if (data_we) data_mem[set_idx][way_q] <= (cur.op == OP_STORE) ? merged : base_line;
    for (int k = 0; k < WAY_COUNT; k++) data_rd[k] <= data_mem[rd_set][k];
  end

`ifndef SYNTHESIS
  a_no_req_while_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !req_ready) else $error("ready during clear");
  a_rsp_after_update: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |=> rsp_valid) else $error("no response after update");
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> clr_cnt[BLK_BITS] || clr_cnt == (BLK_BITS+1)'(MEM_WORDS-1))
    else $error("idle before clear");
`endif
endmodule
